// ----- hdl/ils_pkg.sv -----
// package: sizes, codes and shared types of the indexed list store
`default_nettype none
package ils_pkg;

	// list capacity and field widths
	localparam int CAPACITY = 64;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int ST_W     = 2;
	localparam int LEN_W    = 7;

	// derived widths
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// read reduction: groups of cells ORed in the first result stage
	localparam int GROUP = 8;
	localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 3'd0,
		CMD_HEAD   = 3'd1,
		CMD_TAIL   = 3'd2,
		CMD_BEFORE = 3'd3,
		CMD_DELETE = 3'd4
	} cmd_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             rd;
		logic [CMP_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

	// result fields settled at accept time
	typedef struct packed {
		logic             rd_ok;
		status_t          status;
		logic [LEN_W-1:0] length;
	} res_meta_t;

endpackage
`default_nettype wire

// ----- hdl/ils_if.sv -----
// interfaces: command channel and result channel
`default_nettype none
interface ils_cmd_if;
	import ils_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [POS_W-1:0] position;
	logic signed [VAL_W-1:0] value_in;

	modport source (output valid, output cmd, output position, output value_in, input ready);
	modport sink   (input valid, input cmd, input position, input value_in, output ready);
endinterface

interface ils_res_if;
	import ils_pkg::*;

	logic             valid;
	logic             ready;
	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]  status;
	logic [LEN_W-1:0] length;

	modport source (output valid, output read_value, output status, output length, input ready);
	modport sink   (input valid, input read_value, input status, input length, output ready);
endinterface
`default_nettype wire

// ----- hdl/ils_cell.sv -----
// list cell: one entry, shifted from either neighbour on insert or delete
`default_nettype none
module ils_cell (
	input  wire logic                    clk,
	input  wire ils_pkg::cell_ctl_t      ctl,
	input  wire logic [ils_pkg::IDX_W-1:0] idx,
	input  wire logic [ils_pkg::VAL_W-1:0] left,
	input  wire logic [ils_pkg::VAL_W-1:0] right,
	output logic      [ils_pkg::VAL_W-1:0] data,
	output logic      [ils_pkg::VAL_W-1:0] rd_data
);
	import ils_pkg::*;

	logic [VAL_W-1:0] data_q;
	logic [CMP_W-1:0] idx_w;

	assign idx_w = CMP_W'(idx);

	// insert: cells past the slot take the left neighbour, the slot loads the value
	// delete: the slot and all after it take the right neighbour
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx_w > ctl.pos) begin
				data_q <= left;
			end else if (idx_w == ctl.pos) begin
				data_q <= ctl.value;
			end
		end else if (ctl.del) begin
			if (idx_w >= ctl.pos) begin
				data_q <= right;
			end
		end
	end

	// entry seen by the neighbours, and masked for the read tree
	assign data    = data_q;
	assign rd_data = (ctl.rd && (idx_w == ctl.pos)) ? data_q : '0;
endmodule
`default_nettype wire

// ----- hdl/ils_res_stage.sv -----
// result path: registered OR tree over the cells and the output register
`default_nettype none
module ils_res_stage (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      fire,
	input  wire logic [ils_pkg::VAL_W-1:0] rd_data [ils_pkg::CAPACITY],
	input  wire ils_pkg::res_meta_t        meta,
	output logic                           in_ready,
	ils_res_if.source                      result
);
	import ils_pkg::*;

	logic [VAL_W-1:0] grp_d [NGRP];
	logic [VAL_W-1:0] grp_s1 [NGRP];
	res_meta_t        meta_s1;
	logic             valid_s1;
	logic             adv;
	logic [VAL_W-1:0] rd_or;

	// first level: OR within each group of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | rd_data[g * GROUP + k];
				end
			end
		end
	end

	// second level: OR across the groups
	always_comb begin
		rd_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_or = rd_or | grp_s1[g];
		end
	end

	// stage moves on when the output register is free or being taken
	assign adv      = valid_s1 && (!result.valid || result.ready);
	assign in_ready = !valid_s1 || adv;

	// stage one payload
	always_ff @(posedge clk) begin
		if (fire) begin
			grp_s1  <= grp_d;
			meta_s1 <= meta;
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			result.read_value <= meta_s1.rd_ok ? rd_or : '1;
			result.status     <= meta_s1.status;
			result.length     <= meta_s1.length;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (adv) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/indexed_list_store_top.sv -----
// top level: command decode, entry count and the row of list cells
//
//  channel   dir  handshake      payload
//  command   in   valid/ready    cmd[3], position[7], value_in[32] signed
//  result    out  valid/ready    read_value[32] signed, status[2], length[7]
//
// one command is taken every cycle while the result path has room; every cell
// shifts in the same cycle as its command is taken
// a result passes through the group OR register of the read tree, then
// the output register
// reset clears the entry count and the valid flags; entries stay unset
// a stalled result holds the output, and one more command is still taken
// into the tree stage before the command side stops
`default_nettype none
module indexed_list_store_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ils_cmd_if.sink    command,
	ils_res_if.source  result
);
	import ils_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] pos_w;
	logic             full;
	logic             fire;
	logic             in_ready;
	logic             do_ins;
	logic             do_del;
	logic             rd_ok;
	logic [CMP_W-1:0] ins_pos;
	status_t          st;
	cell_ctl_t        ctl;
	res_meta_t        meta;
	logic [VAL_W-1:0] data_w [CAPACITY];
	logic [VAL_W-1:0] rd_w   [CAPACITY];

	assign command.ready = in_ready;
	assign fire  = command.valid && in_ready;
	assign cnt_w = CMP_W'(count_q);
	assign pos_w = CMP_W'(command.position);
	assign full  = (count_q == CNT_W'(CAPACITY));

	// command decode against the current count
	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		rd_ok   = 1'b0;
		ins_pos = pos_w;
		st      = ST_DONE;
		unique case (cmd_t'(command.cmd))
			CMD_READ: begin
				if (pos_w < cnt_w) rd_ok = 1'b1;
				else st = ST_RANGE;
			end
			CMD_HEAD: begin
				ins_pos = '0;
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			CMD_TAIL: begin
				ins_pos = cnt_w;
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			CMD_BEFORE: begin
				if (pos_w > cnt_w) st = ST_RANGE;
				else if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			CMD_DELETE: begin
				if (pos_w < cnt_w) do_del = 1'b1;
				else st = ST_RANGE;
			end
			default: begin
			end
		endcase
	end

	// count after this command
	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_del) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

	// broadcast to the cells, live only on an accepted item
	always_comb begin
		ctl.ins    = fire && do_ins;
		ctl.del    = fire && do_del;
		ctl.rd     = fire && rd_ok;
		ctl.pos    = ins_pos;
		ctl.value  = command.value_in;
		meta.rd_ok  = rd_ok;
		meta.status = st;
		meta.length = LEN_W'(count_d);
	end

	// row of cells, each wired to both neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_w;
		logic [VAL_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = data_w[i+1];
		end

		ils_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.idx     (IDX_W'(i)),
			.left    (left_w),
			.right   (right_w),
			.data    (data_w[i]),
			.rd_data (rd_w[i])
		);
	end

	ils_res_stage u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.rd_data  (rd_w),
		.meta     (meta),
		.in_ready (in_ready),
		.result   (result)
	);
endmodule
`default_nettype wire

// ----- hdl/ils_chk.sv -----
// checker on the top level ports, bound to the top level
`default_nettype none
module ils_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      r_valid,
	input wire logic                      r_ready,
	input wire logic [ils_pkg::VAL_W-1:0] r_value,
	input wire logic [ils_pkg::ST_W-1:0]  r_status,
	input wire logic [ils_pkg::LEN_W-1:0] r_length
);
	import ils_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its fields
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_value) && $stable(r_status) && $stable(r_length))
		else $error("result fields changed while stalled");

	// length never passes the capacity
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_length <= LEN_W'(CAPACITY))
		else $error("length beyond capacity");

	// a dropped insert for a full store reports a full list
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_status == ST_FULL |-> r_length == LEN_W'(CAPACITY))
		else $error("full status with room left");

	// any failed command gives the all-ones read value
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_status != ST_DONE |-> r_value == '1)
		else $error("read value set on a failed command");
endmodule

bind indexed_list_store_top ils_chk u_ils_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.r_valid  (result.valid),
	.r_ready  (result.ready),
	.r_value  (result.read_value),
	.r_status (result.status),
	.r_length (result.length)
);
`default_nettype wire
